[sv/hcbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Command codes, field widths, parameter defaults and the request and
// response records that pass between the table and the packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOL_COUNT = 256;

	localparam int SYM_BITS  = 8;   // symbol field
	localparam int WORD_BITS = 32;  // code_word field
	localparam int LEN_BITS  = 6;   // code_length field
	localparam int BYTE_BITS = 8;   // one packed byte
	localparam int PEND_BITS = 7;   // leftover bits held between items
	localparam int CNT_BITS  = 3;   // count of leftover bits

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	// table access issued in the accept cycle
	typedef struct packed {
		logic                 wr;
		logic                 rd;
		logic [SYM_BITS-1:0]  sym;
		logic [WORD_BITS-1:0] code;
		logic [LEN_BITS-1:0]  len;
	} tbl_req_t;

	// lookup result, valid the cycle after a read
	typedef struct packed {
		logic [LEN_BITS-1:0]  len;
		logic [WORD_BITS-1:0] code;
	} tbl_rsp_t;

endpackage

[sv/hcbp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/hcbp_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_table: code table (code bits and length per symbol)
// One RAM holds length and code; per-entry valid bits make unwritten
// entries read as length zero right after reset.
// ----------------------------------------------------------------------------
module hcbp_table #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbp_pkg::tbl_req_t  req,
	output hcbp_pkg::tbl_rsp_t  rsp
);

	localparam int CODE_W  = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ?
		MAX_CODE_LEN : hcbp_pkg::WORD_BITS;
	localparam int LEN_CAP = CODE_W;
	localparam int IDX_W   = $clog2(SYMBOL_COUNT);
	localparam int ENT_W   = CODE_W + hcbp_pkg::LEN_BITS;

	logic                          in_range;
	logic [IDX_W-1:0]              idx;
	logic [hcbp_pkg::LEN_BITS-1:0] len_c;
	logic [63:0]                   mask;
	logic [CODE_W-1:0]             code_c;
	logic [ENT_W-1:0]              rd_ent;
	logic [SYMBOL_COUNT-1:0]       valid_q;
	logic                          hit_s1;

	assign in_range = {1'b0, req.sym} < (hcbp_pkg::SYM_BITS + 1)'(SYMBOL_COUNT);
	assign idx      = req.sym[IDX_W-1:0];

	// saturate length, drop stray code bits above it
	always_comb begin
		len_c = (req.len > hcbp_pkg::LEN_BITS'(LEN_CAP)) ?
			hcbp_pkg::LEN_BITS'(LEN_CAP) : req.len;
		mask   = (64'd1 << len_c) - 64'd1;
		code_c = req.code[CODE_W-1:0] & mask[CODE_W-1:0];
	end

	hcbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SYMBOL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (req.wr && in_range),
		.waddr(idx),
		.wdata({len_c, code_c}),
		.re   (req.rd),
		.raddr(idx),
		.rdata(rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (req.wr && in_range) begin
				valid_q[idx] <= 1'b1;
			end
			if (req.rd) begin
				hit_s1 <= in_range && valid_q[idx];
			end
		end
	end

	// unwritten entries read as no code at all
	assign rsp.len  = hit_s1 ? rd_ent[ENT_W-1 -: hcbp_pkg::LEN_BITS] : '0;
	assign rsp.code = hit_s1 ? hcbp_pkg::WORD_BITS'(rd_ent[CODE_W-1:0]) : '0;

endmodule

[sv/hcbp_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_packer: bit accumulator, byte emitter and output register
// Merges a looked-up code behind the leftover bits (or pads them on a flush),
// then shifts out one byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module hcbp_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  hcbp_pkg::cmd_t                 cmd,
	output logic                           ready,
	input  hcbp_pkg::tbl_rsp_t             lk,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
	output logic                           out_last
);

	localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ?
		MAX_CODE_LEN : hcbp_pkg::WORD_BITS;
	localparam int ACC_W  = hcbp_pkg::PEND_BITS + CODE_W;
	localparam int TOT_W  = $clog2(ACC_W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [ACC_W-1:0]               acc_q;
	logic [TOT_W-1:0]               total_q;
	logic [hcbp_pkg::PEND_BITS-1:0] pend_q;
	logic [hcbp_pkg::CNT_BITS-1:0]  pcnt_q;
	logic                           out_valid_q;
	logic [hcbp_pkg::BYTE_BITS-1:0] out_byte_q;
	logic                           out_last_q;

	logic [ACC_W-1:0]               acc_new;
	logic [TOT_W-1:0]               tot_new;
	logic [hcbp_pkg::BYTE_BITS-1:0] flush_byte;
	logic [ACC_W-1:0]               shifted;
	logic [TOT_W-1:0]               tot_rem;
	logic [hcbp_pkg::PEND_BITS-1:0] rem_mask;
	logic                           out_free;
	logic                           emit;

	always_comb begin
		acc_new    = (ACC_W'(pend_q) << lk.len) | ACC_W'(lk.code[CODE_W-1:0]);
		tot_new    = TOT_W'(pcnt_q) + TOT_W'(lk.len);
		flush_byte = hcbp_pkg::BYTE_BITS'(pend_q) << (4'd8 - 4'(pcnt_q));
		tot_rem    = total_q - TOT_W'(hcbp_pkg::BYTE_BITS);
		shifted    = acc_q >> tot_rem;
		rem_mask   = (hcbp_pkg::PEND_BITS'(1) << tot_rem[hcbp_pkg::CNT_BITS-1:0]) -
			hcbp_pkg::PEND_BITS'(1);
		out_free   = !out_valid_q || out_ready;
		emit       = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			total_q     <= '0;
			pend_q      <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// output register: load a new byte or drop the one just taken
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= shifted[hcbp_pkg::BYTE_BITS-1:0];
				out_last_q  <= tot_rem < TOT_W'(hcbp_pkg::BYTE_BITS);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd == hcbp_pkg::CMD_ENCODE) begin
						state_q <= ST_LOOK;
					end else if (accept && cmd == hcbp_pkg::CMD_FLUSH && pcnt_q != '0) begin
						acc_q   <= ACC_W'(flush_byte);
						total_q <= TOT_W'(hcbp_pkg::BYTE_BITS);
						state_q <= ST_EMIT;
					end
				end
				ST_LOOK: begin
					if (tot_new >= TOT_W'(hcbp_pkg::BYTE_BITS)) begin
						acc_q   <= acc_new;
						total_q <= tot_new;
						state_q <= ST_EMIT;
					end else begin
						// fewer than eight bits: all stays pending
						pend_q  <= acc_new[hcbp_pkg::PEND_BITS-1:0];
						pcnt_q  <= tot_new[hcbp_pkg::CNT_BITS-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						total_q <= tot_rem;
						if (tot_rem < TOT_W'(hcbp_pkg::BYTE_BITS)) begin
							pend_q  <= acc_q[hcbp_pkg::PEND_BITS-1:0] & rem_mask;
							pcnt_q  <= tot_rem[hcbp_pkg::CNT_BITS-1:0];
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready     = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// a byte run always holds at least one full byte
	a_emit_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (total_q >= TOT_W'(hcbp_pkg::BYTE_BITS)))
		else $error("emit state without a full byte");

	// flush of leftover bits yields exactly one byte
	a_flush_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == hcbp_pkg::CMD_FLUSH && pcnt_q != '0) |=>
		(state_q == ST_EMIT && total_q == TOT_W'(hcbp_pkg::BYTE_BITS)))
		else $error("flush did not start a single byte");

	// last flag set exactly on the byte that ends the run
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_last_q == (state_q == ST_IDLE)))
		else $error("last flag out of step with end of run");

	// pending bits above the count are always zero
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		((pend_q >> pcnt_q) == hcbp_pkg::PEND_BITS'(0)))
		else $error("stray pending bits");

endmodule

[sv/huffman_code_bit_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit: table-driven Huffman encoder
// Loads per-symbol codes into a table, appends looked-up codes to a bit
// accumulator and streams out complete bytes, earliest bit in bit 7.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser / tlast
//  --------+-----+--------------------------------------------+-----------------
//  s_*     | in  | symbol[7:0], code_word[39:8],              | tuser[1:0]=command
//          |     | code_length[45:40], zero pad [47:46]       |
//  m_*     | out | packed_byte[7:0]                           | tlast=last_of_run
//
//  Steps: load writes the table; flush yields 0 or 1 byte; encode reads the
//  table RAM, merges the returned code in the lookup state, then emits 0..4 bytes.
//  Input is taken only while the packer is idle; the final byte of an item
//  may still sit in the output register while the next item is accepted.
//  Reset: arst_n clears control state and all table valid bits, so every
//  symbol starts with no code; no clearing pass is needed.
//  Stalls: m_tready low holds the output register and the byte emitter.
//
module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40]
	input  logic [1:0]  s_tuser,   // command[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // packed_byte[7:0]
	output logic        m_tlast
);

	logic               accept;
	hcbp_pkg::cmd_t     cmd;
	hcbp_pkg::tbl_req_t req;
	hcbp_pkg::tbl_rsp_t rsp;

	assign accept = s_tvalid && s_tready;
	assign cmd    = hcbp_pkg::cmd_t'(s_tuser);

	// table access is issued in the accept cycle; the registered read returns in the next cycle
	always_comb begin
		req.wr   = accept && (cmd == hcbp_pkg::CMD_LOAD);
		req.rd   = accept && (cmd == hcbp_pkg::CMD_ENCODE);
		req.sym  = s_tdata[7:0];
		req.code = s_tdata[39:8];
		req.len  = s_tdata[45:40];
	end

	hcbp_table #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	hcbp_packer #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.ready    (s_tready),
		.lk       (rsp),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

endmodule

[sim/huffman_code_bit_packer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit_tb: self-checking bench for the code packer
// Drives load, encode and flush words with random source gaps and sink
// stalls. A shadow code table and bit accumulator predict every packed byte
// and its tlast, and each output word is checked in order against them.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;  // reserved command, ignored
	localparam int LEN_CAP = (hcbp_pkg::DEF_MAX_CODE_LEN < 32) ?
		hcbp_pkg::DEF_MAX_CODE_LEN : 32;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_WORDS = 290;

	typedef struct {
		logic [hcbp_pkg::BYTE_BITS-1:0] packed_byte;
		logic                           last_of_run;
	} packed_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// shadow of the block state
	logic [hcbp_pkg::WORD_BITS-1:0] code_tbl [hcbp_pkg::DEF_SYMBOL_COUNT];
	logic [hcbp_pkg::LEN_BITS-1:0]  len_tbl  [hcbp_pkg::DEF_SYMBOL_COUNT];
	logic [hcbp_pkg::PEND_BITS-1:0] pend_bits = '0;
	int                             pend_cnt = 0;

	packed_out_t expected_bytes[$];
	logic [hcbp_pkg::SYM_BITS-1:0] known_syms[$];
	bit   loaded [hcbp_pkg::DEF_SYMBOL_COUNT];
	int   errors = 0;
	int   idle_cycles = 0;
	int   rx_wait = 0;
	bit   no_gaps = 1'b0;
	bit   rx_quiet = 1'b0;

	huffman_code_bit_packer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	initial begin
		foreach (len_tbl[i]) begin
			len_tbl[i] = '0;
			code_tbl[i] = '0;
			loaded[i] = 1'b0;
		end
	end

	// Shadow packer: applies one accepted word, queues the bytes it yields.
	task automatic pack_code_bits(input logic [1:0] cmd,
			input logic [hcbp_pkg::SYM_BITS-1:0] sym,
			input logic [hcbp_pkg::WORD_BITS-1:0] code,
			input logic [hcbp_pkg::LEN_BITS-1:0] len);
		logic [63:0] acc;
		int          total;
		int          n;
		int          use_len;
		packed_out_t outs[4];
		n = 0;
		case (cmd)
			hcbp_pkg::CMD_LOAD: begin
				use_len = (len > LEN_CAP) ? LEN_CAP : len;
				len_tbl[sym] = use_len[hcbp_pkg::LEN_BITS-1:0];
				code_tbl[sym] = code &
					hcbp_pkg::WORD_BITS'((64'd1 << use_len) - 64'd1);
			end
			hcbp_pkg::CMD_ENCODE: begin
				use_len = len_tbl[sym];
				if (use_len != 0) begin
					acc = (64'(pend_bits) << use_len) | 64'(code_tbl[sym]);
					total = pend_cnt + use_len;
					while (total >= 8 && n < 4) begin
						outs[n].packed_byte = 8'(acc >> (total - 8));
						outs[n].last_of_run = 1'b0;
						n++;
						total -= 8;
					end
					pend_cnt = total;
					pend_bits = hcbp_pkg::PEND_BITS'(acc & ((64'd1 << total) - 64'd1));
				end
			end
			hcbp_pkg::CMD_FLUSH: begin
				if (pend_cnt != 0) begin
					outs[0].packed_byte = 8'({1'b0, pend_bits} << (8 - pend_cnt));
					outs[0].last_of_run = 1'b0;
					n = 1;
					pend_bits = '0;
					pend_cnt = 0;
				end
			end
			default: ;  // reserved command: no effect
		endcase
		if (n > 0)
			outs[n-1].last_of_run = 1'b1;
		for (int k = 0; k < n; k++)
			expected_bytes.push_back(outs[k]);
	endtask

	// input monitor feeds the shadow packer on every accepted word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pack_code_bits(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[45:40]);
	end

	// sink side: random stall per received word, or none while quiet
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// output check against the oldest expected byte
	always @(posedge clk) begin
		packed_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected output word: packed_byte %02h last_of_run %0b",
					m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.packed_byte) begin
					$error("packed_byte: expected %02h, actual %02h", want.packed_byte, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] cmd,
			input logic [hcbp_pkg::SYM_BITS-1:0] sym,
			input logic [hcbp_pkg::WORD_BITS-1:0] code,
			input logic [hcbp_pkg::LEN_BITS-1:0] len);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, len, code, sym};
		do @(posedge clk); while (!s_tready);
		if (cmd == hcbp_pkg::CMD_LOAD && !loaded[sym]) begin
			loaded[sym] = 1'b1;
			known_syms.push_back(sym);
		end
	endtask

	// empty flush and the reserved command yield nothing
	task automatic test_idle_commands();
		send_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'hFFFF_FFFF, 6'h3F);
		send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		send_word(CMD_UNUSED, 8'h00, 32'h0000_0000, 6'h00);
	endtask

	// longest and shortest codes, symbol extremes, byte-aligned code
	task automatic test_length_extremes();
		send_word(hcbp_pkg::CMD_LOAD, 8'h00, 32'h0000_0001, 6'd1);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
		send_word(hcbp_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		send_word(hcbp_pkg::CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'h00);  // 33 bits: four bytes
		send_word(hcbp_pkg::CMD_LOAD, 8'h28, 32'h0000_0000, 6'd32);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h28, 32'h1234_5678, 6'd5);
		send_word(hcbp_pkg::CMD_FLUSH, 8'hAA, 32'h0, 6'd0);
		send_word(hcbp_pkg::CMD_FLUSH, 8'h55, 32'h0, 6'd0);            // nothing left
		send_word(hcbp_pkg::CMD_LOAD, 8'h32, 32'h0000_00A5, 6'd8);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h32, 32'h0, 6'd0);           // exactly one byte
		send_word(hcbp_pkg::CMD_FLUSH, 8'h32, 32'h0, 6'd0);
	endtask

	// saturated length, dropped high bits, zero-length code
	task automatic test_code_cleanup();
		send_word(hcbp_pkg::CMD_LOAD, 8'h0A, 32'hDEAD_BEEF, 6'd63);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h0A, 32'h0, 6'd0);
		send_word(hcbp_pkg::CMD_LOAD, 8'h0B, 32'hCAFE_F00D, 6'd33);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h0B, 32'h0, 6'd0);
		send_word(hcbp_pkg::CMD_LOAD, 8'h14, 32'hFFFF_FFFF, 6'd3);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h14, 32'h0, 6'd0);
		send_word(hcbp_pkg::CMD_LOAD, 8'h1E, 32'h8765_4321, 6'd0);
		send_word(hcbp_pkg::CMD_ENCODE, 8'h1E, 32'h0, 6'd0);           // no code: no output
		send_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
	endtask

	// a small dictionary first, then mostly encodes with loads, flushes, noise
	task automatic test_random_traffic();
		int r;
		int len;
		logic [hcbp_pkg::SYM_BITS-1:0] sym;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_gaps = (i % 120) >= 80;
			rx_quiet = (i % 90) >= 60;
			r = (i < 16) ? 0 : $urandom_range(0, 99);
			if (r < 12) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: len = $urandom_range(1, 9);
					6, 7: len = $urandom_range(10, 32);
					8: len = 0;
					default: len = $urandom_range(33, 63);
				endcase
				send_word(hcbp_pkg::CMD_LOAD, 8'($urandom), $urandom, 6'(len));
			end else if (r < 82) begin
				sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
				send_word(hcbp_pkg::CMD_ENCODE, sym, $urandom, 6'($urandom));
			end else if (r < 93) begin
				send_word(hcbp_pkg::CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
			end else begin
				send_word(CMD_UNUSED, 8'($urandom), $urandom, 6'($urandom));
			end
		end
		send_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_commands();
		test_length_extremes();
		test_code_cleanup();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
